FILE: rtl/bav_pkg.sv
// Shared constants, field offsets and the control/status types of the beacon angle validator.
// Used by every module under rtl; depends on nothing else.
`default_nettype none

package bav_pkg;

	// Sizes of the beacon store and of the validation pass.
	localparam int STORED_BEACONS_DEF = 5;
	localparam int CHECKED_BEACONS    = 4;
	localparam int TRIGGER_BEACON     = 3;
	localparam int CHECK_INTERVAL     = 4;
	localparam int ENOUGH_VALID       = 3;

	// Field widths.
	localparam int BEACON_W = 3;
	localparam int TIMER_W  = 16;
	localparam int ANGLE_W  = 15;
	localparam int COUNT_W  = 3;
	localparam int MASK_W   = 4;

	// The quotient of (elapsed << ANGLE_W) / period takes one step per dividend bit.
	localparam int DIV_STEPS = TIMER_W + ANGLE_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// Configuration port.
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_TIME_TOL  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_TOL = 1'b1;
	localparam logic [CFG_W-1:0] TIME_TOL_RST  = 16'd10;
	localparam logic [CFG_W-1:0] ANGLE_TOL_RST = 16'd3641;

	// Stream words, padded to whole bytes.
	localparam int IN_TDATA_W  = 88;
	localparam int OUT_TDATA_W = 88;
	localparam int OUT_USED_W  = 4 * ANGLE_W + ANGLE_W + 1 + MASK_W + COUNT_W + 1;

	// Input word layout, lowest bit first.
	localparam int IN_BEACON_LSB   = 0;
	localparam int IN_CAPTURE_LSB  = IN_BEACON_LSB + BEACON_W;
	localparam int IN_START_LSB    = IN_CAPTURE_LSB + TIMER_W;
	localparam int IN_TOP_CUR_LSB  = IN_START_LSB + TIMER_W;
	localparam int IN_TOP_PREV_LSB = IN_TOP_CUR_LSB + TIMER_W;
	localparam int IN_TURN_LSB     = IN_TOP_PREV_LSB + TIMER_W;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;    // a word is taken from the input: capture it and start the divider
		logic commit;  // update the beacon store and load the output register
	} bav_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic div_done;  // single-cycle pulse when the quotient is complete
	} bav_status_t;

endpackage

`default_nettype wire

FILE: rtl/bav_divider.sv
// Restoring bit-serial divider: (elapsed << 15) / period, keeping the low 15 quotient bits.
// Depends on bav_pkg for widths and the step count.
`default_nettype none

module bav_divider
	import bav_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [TIMER_W-1:0] elapsed,
	input  wire logic [TIMER_W-1:0] period,
	output logic                    done,
	output logic [ANGLE_W-1:0]      quotient
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [TIMER_W-1:0]   rem_q;
	logic [TIMER_W-1:0]   dvd_q;
	logic [TIMER_W-1:0]   div_q;
	logic [ANGLE_W-1:0]   quo_q;

	logic [TIMER_W:0] trial;
	logic [TIMER_W:0] diff;
	logic             q_bit;

	// The remainder always stays below the divisor, so the trial value fits in 17 bits.
	always_comb begin
		trial = {rem_q, dvd_q[TIMER_W-1]};
		diff  = trial - {1'b0, div_q};
		q_bit = (trial >= {1'b0, div_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_STEPS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= elapsed;
			div_q <= period;
		end else if (busy_q) begin
			rem_q <= q_bit ? diff[TIMER_W-1:0] : trial[TIMER_W-1:0];
			dvd_q <= {dvd_q[TIMER_W-2:0], 1'b0};
			quo_q <= {quo_q[ANGLE_W-2:0], q_bit};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

FILE: rtl/bav_datapath.sv
// Datapath: input capture, angle divider, per-beacon store, validation and output register.
// Depends on bav_pkg and instantiates bav_divider.
`default_nettype none

module bav_datapath
	import bav_pkg::*;
#(
	parameter int STORED_BEACONS = STORED_BEACONS_DEF
)(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_W-1:0]       cfg_data,
	input  wire bav_cmd_t               cmd,
	output bav_status_t                 status,
	output logic [OUT_TDATA_W-1:0]      m_tdata
);

	localparam int SB_W = BEACON_W + 1;

	logic [CFG_W-1:0] time_tol_q;
	logic [CFG_W-1:0] angle_tol_q;

	logic [BEACON_W-1:0] beacon_q;
	logic [TIMER_W-1:0]  turn_q;
	logic                zero_period_q;

	logic [ANGLE_W-1:0] latest_q  [STORED_BEACONS];
	logic [ANGLE_W-1:0] earlier_q [STORED_BEACONS];
	logic [TIMER_W-1:0] stamp_q   [STORED_BEACONS];
	logic [MASK_W-1:0]  valid_q;
	logic [COUNT_W-1:0] dets_q;
	logic [OUT_TDATA_W-1:0] out_q;

	logic [ANGLE_W-1:0] latest_nx  [STORED_BEACONS];
	logic [ANGLE_W-1:0] earlier_nx [STORED_BEACONS];
	logic [TIMER_W-1:0] stamp_nx   [STORED_BEACONS];

	logic [TIMER_W-1:0] elapsed;
	logic [TIMER_W-1:0] period;
	logic [ANGLE_W-1:0] quotient;
	logic [ANGLE_W-1:0] angle;
	logic               div_done;
	logic               stored;
	logic               check;
	logic [COUNT_W-1:0] dets_nx;
	logic [MASK_W-1:0]  pass;
	logic [MASK_W-1:0]  valid_nx;
	logic [COUNT_W-1:0] valid_cnt;
	logic [ANGLE_W-1:0] lane_angle [CHECKED_BEACONS];

	// Both differences wrap at 16 bits.
	assign elapsed = s_tdata[IN_START_LSB-1:IN_CAPTURE_LSB] - s_tdata[IN_TOP_CUR_LSB-1:IN_START_LSB];
	assign period  = s_tdata[IN_TOP_PREV_LSB-1:IN_TOP_CUR_LSB] -
		s_tdata[IN_TURN_LSB-1:IN_TOP_PREV_LSB];

	bav_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.load),
		.elapsed  (elapsed),
		.period   (period),
		.done     (div_done),
		.quotient (quotient)
	);

	assign status.div_done = div_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_tol_q  <= TIME_TOL_RST;
			angle_tol_q <= ANGLE_TOL_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TIME_TOL:  time_tol_q  <= cfg_data;
				REG_ANGLE_TOL: angle_tol_q <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			beacon_q      <= s_tdata[IN_CAPTURE_LSB-1:IN_BEACON_LSB];
			turn_q        <= s_tdata[IN_TURN_LSB+TIMER_W-1:IN_TURN_LSB];
			zero_period_q <= (period == '0);
		end
	end

	// A zero period gives angle zero instead of the divider's all-ones quotient.
	assign angle  = zero_period_q ? '0 : quotient;
	assign stored = {1'b0, beacon_q} < SB_W'(STORED_BEACONS);

	always_comb begin
		for (int e = 0; e < STORED_BEACONS; e++) begin
			if (stored && beacon_q == BEACON_W'(e)) begin
				latest_nx[e]  = angle;
				earlier_nx[e] = latest_q[e];
				stamp_nx[e]   = turn_q;
			end else begin
				latest_nx[e]  = latest_q[e];
				earlier_nx[e] = earlier_q[e];
				stamp_nx[e]   = stamp_q[e];
			end
		end
	end

	assign dets_nx = dets_q + 1'b1;
	assign check   = (stored && beacon_q == BEACON_W'(TRIGGER_BEACON)) ||
		(dets_nx > COUNT_W'(CHECK_INTERVAL));

	// One lane per checked beacon; a beacon outside the store always fails.
	for (genvar i = 0; i < CHECKED_BEACONS; i++) begin : g_lane
		if (i < STORED_BEACONS) begin : g_stored
			logic [TIMER_W-1:0] age;
			logic [ANGLE_W-1:0] delta;
			assign age   = turn_q - stamp_nx[i];
			assign delta = (latest_nx[i] >= earlier_nx[i]) ? latest_nx[i] - earlier_nx[i]
				: earlier_nx[i] - latest_nx[i];
			assign pass[i] = (age < time_tol_q) && ({1'b0, delta} < angle_tol_q);
			assign lane_angle[i] = latest_nx[i];
		end else begin : g_absent
			assign pass[i]       = 1'b0;
			assign lane_angle[i] = '0;
		end
	end

	assign valid_nx  = check ? pass : valid_q;
	assign valid_cnt = COUNT_W'(valid_nx[0]) + COUNT_W'(valid_nx[1]) +
		COUNT_W'(valid_nx[2]) + COUNT_W'(valid_nx[3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int e = 0; e < STORED_BEACONS; e++) begin
				latest_q[e]  <= '0;
				earlier_q[e] <= '0;
				stamp_q[e]   <= '0;
			end
			valid_q <= '0;
			dets_q  <= '0;
		end else if (cmd.commit) begin
			for (int e = 0; e < STORED_BEACONS; e++) begin
				latest_q[e]  <= latest_nx[e];
				earlier_q[e] <= earlier_nx[e];
				stamp_q[e]   <= stamp_nx[e];
			end
			valid_q <= valid_nx;
			dets_q  <= check ? '0 : dets_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_q <= {(OUT_TDATA_W - OUT_USED_W)'(0), lane_angle[3], lane_angle[2],
				lane_angle[1], lane_angle[0], (valid_cnt >= COUNT_W'(ENOUGH_VALID)),
				valid_cnt, valid_nx, check, angle};
		end
	end

	assign m_tdata = out_q;

endmodule

`default_nettype wire

FILE: rtl/bav_ctrl.sv
// Controller: sequences capture, division and commit, and owns the output valid flag.
// Depends on bav_pkg for the command and status types.
`default_nettype none

module bav_ctrl
	import bav_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  s_tvalid,
	output logic       s_tready,
	output logic       m_tvalid,
	input  wire logic  m_tready,
	output bav_cmd_t   cmd,
	input  wire bav_status_t status
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_COMMIT
	} state_t;

	state_t state_q;
	logic   m_tvalid_q;

	// The result is committed once the output register is free or is being emptied.
	always_comb begin
		s_tready   = (state_q == ST_IDLE);
		cmd.load   = s_tready && s_tvalid;
		cmd.commit = (state_q == ST_COMMIT) && (!m_tvalid_q || m_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.load) state_q <= ST_DIVIDE;
				end
				ST_DIVIDE: begin
					if (status.div_done) state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					if (cmd.commit) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;

endmodule

`default_nettype wire

FILE: rtl/beacon_angle_validator.sv
// Beacon angle validator: one result word per detection word. From acceptance to the result
// come 31 bit-serial divider steps, the controller seeing the divider finish, and the commit.
// The next word is taken in the cycle after the commit, so a new word waits until the last one
// is committed; a result still waiting in the output register delays the next commit.
// arst_n clears the beacon store, the status mask and the detection counter, and restores the
// tolerance registers to 10 turns and 3641/32768 of a turn.
`default_nettype none

module beacon_angle_validator
	import bav_pkg::*;
#(
	parameter int STORED_BEACONS = STORED_BEACONS_DEF
)(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// Detection words.
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// From bit 0: beacon(3), capture_time(16), turn_start(16), top_current(16),
	// top_previous(16), turn_count(16), zero padding.
	input  wire logic [IN_TDATA_W-1:0] s_tdata,
	// Result words.
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// From bit 0: angle(15), validated(1), status_mask(4), valid_count(3), enough_valid(1),
	// angle_zero(15), angle_one(15), angle_two(15), angle_three(15), zero padding.
	output logic [OUT_TDATA_W-1:0]     m_tdata,
	// Register writes: index 0 is time_tolerance, index 1 is angle_tolerance.
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_W-1:0]      cfg_data
);

	// The controller only steps the sequence; all arithmetic and storage sits in the datapath.
	bav_cmd_t    cmd;
	bav_status_t status;

	bav_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.status   (status)
	);

	// The datapath keeps the latest and earlier angle and a turn stamp for every stored
	// beacon, and runs the validation of beacons 0 to 3 in the commit cycle.
	bav_datapath #(
		.STORED_BEACONS (STORED_BEACONS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.m_tdata   (m_tdata)
	);

endmodule

`default_nettype wire
